[hw/rtl/hermite_contrast_curve_point_defines.svh]
// Assertion macros shared by the contrast curve point RTL.
// Used by files that include it inside a module with clk and rst_n in scope.
`ifndef HERMITE_CONTRAST_CURVE_POINT_DEFINES_SVH
`define HERMITE_CONTRAST_CURVE_POINT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define HCCP_CHECK(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define HCCP_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/hccp_pkg.sv]
// Package for the contrast curve point block: widths, fixed-point constants
// and the sideband struct carried through the divider. No dependencies.
package hccp_pkg;

  localparam int LEVEL_BITS = 8;
  localparam int SLOPE_BITS = 12;
  localparam int SLOPE_FRAC = 8;
  localparam int FRAC_BITS  = 16;
  localparam int T_BITS     = FRAC_BITS + 1;
  localparam int NUM_BITS   = LEVEL_BITS + FRAC_BITS;
  localparam int DIV_STEPS  = T_BITS;
  localparam int SQ_BITS    = 2 * T_BITS;
  localparam int H_BITS     = T_BITS + 3;
  localparam int PY_BITS    = H_BITS + LEVEL_BITS + 1;
  localparam int PM_BITS    = H_BITS + SLOPE_BITS;
  localparam int MS_BITS    = PM_BITS + 1 + LEVEL_BITS + 1;
  localparam int SUM_BITS   = LEVEL_BITS + 30;
  localparam int OUT_SHIFT  = FRAC_BITS + SLOPE_FRAC;

  localparam logic [T_BITS-1:0]          T_ONE     = T_BITS'(1) << FRAC_BITS;
  localparam logic signed [H_BITS-1:0]   T_ONE_H   = H_BITS'(T_ONE);
  localparam logic [SQ_BITS-1:0]         SQ_ROUND  = SQ_BITS'(1) << (FRAC_BITS - 1);
  localparam logic signed [SUM_BITS-1:0] OUT_ROUND = SUM_BITS'(1) << (OUT_SHIFT - 1);
  localparam logic [LEVEL_BITS-1:0]      LVL_MAX   = '1;

  typedef logic [LEVEL_BITS-1:0] lvl_t;
  typedef logic signed [SLOPE_BITS-1:0] slope_t;

  // Operands that ride alongside the quotient through the divider.
  typedef struct packed {
    logic   zspan;
    lvl_t   span;
    lvl_t   ly;
    lvl_t   ry;
    slope_t m1;
    slope_t m2;
  } side_t;

endpackage

[hw/rtl/hccp_div.sv]
// Pipelined restoring divider: one quotient bit per register stage.
// Depends on hccp_pkg; the divisor is the span carried in the sideband.
module hccp_div
  import hccp_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [NUM_BITS-1:0] in_num,
  input  side_t               in_side,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [T_BITS-1:0]   out_quo,
  output side_t               out_side
);

  logic [DIV_STEPS-1:0]  vld_r;
  logic [DIV_STEPS-1:0]  vld_nxt;
  logic [DIV_STEPS-1:0]  rdy;
  logic [LEVEL_BITS-1:0] rem_r   [DIV_STEPS];
  logic [LEVEL_BITS-1:0] rem_nxt [DIV_STEPS];
  logic [T_BITS-1:0]     lo_r    [DIV_STEPS];
  logic [T_BITS-1:0]     lo_nxt  [DIV_STEPS];
  logic [T_BITS-1:0]     quo_r   [DIV_STEPS];
  logic [T_BITS-1:0]     quo_nxt [DIV_STEPS];
  side_t                 side_r  [DIV_STEPS];
  side_t                 side_nxt[DIV_STEPS];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic [LEVEL_BITS-1:0] rem_src;
    logic [T_BITS-1:0]     lo_src;
    logic [T_BITS-1:0]     quo_src;
    side_t                 side_src;
    logic [LEVEL_BITS:0]   trial;
    logic                  ge;

    // The first stage takes the upper numerator bits as its partial remainder.
    if (k == 0) begin : g_first
      assign rem_src    = LEVEL_BITS'(in_num[NUM_BITS-1:T_BITS]);
      assign lo_src     = in_num[T_BITS-1:0];
      assign quo_src    = '0;
      assign side_src   = in_side;
      assign vld_nxt[k] = in_valid;
    end else begin : g_next
      assign rem_src    = rem_r[k-1];
      assign lo_src     = lo_r[k-1];
      assign quo_src    = quo_r[k-1];
      assign side_src   = side_r[k-1];
      assign vld_nxt[k] = vld_r[k-1];
    end

    // Shift in the next numerator bit, then compare and subtract once.
    assign trial       = {rem_src, lo_src[T_BITS-1]};
    assign ge          = trial >= {1'b0, side_src.span};
    assign rem_nxt[k]  = ge ? LEVEL_BITS'(trial - {1'b0, side_src.span})
                            : trial[LEVEL_BITS-1:0];
    assign lo_nxt[k]   = {lo_src[T_BITS-2:0], 1'b0};
    assign quo_nxt[k]  = {quo_src[T_BITS-2:0], ge};
    assign side_nxt[k] = side_src;

    // A stage moves when it is empty or the stage after it moves.
    if (k == DIV_STEPS - 1) begin : g_last_rdy
      assign rdy[k] = ~vld_r[k] | out_ready;
    end else begin : g_mid_rdy
      assign rdy[k] = ~vld_r[k] | rdy[k+1];
    end
  end

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int k = 0; k < DIV_STEPS; k++) begin
        if (rdy[k]) begin
          vld_r[k] <= vld_nxt[k];
        end
      end
    end
  end

  // Stage payload.
  always_ff @(posedge clk) begin
    for (int k = 0; k < DIV_STEPS; k++) begin
      if (rdy[k]) begin
        rem_r[k]  <= rem_nxt[k];
        lo_r[k]   <= lo_nxt[k];
        quo_r[k]  <= quo_nxt[k];
        side_r[k] <= side_nxt[k];
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = vld_r[DIV_STEPS-1];
  assign out_quo   = quo_r[DIV_STEPS-1];
  assign out_side  = side_r[DIV_STEPS-1];

endmodule

[hw/rtl/hermite_contrast_curve_point.sv]
// Top level of the contrast curve point: cubic Hermite evaluation pipeline.
// Depends on hccp_pkg, hccp_div and hermite_contrast_curve_point_defines.svh.
//
//   channel | ports                                   | transaction
//   --------+-----------------------------------------+-------------------------------
//   in      | in_valid/in_ready, two points, position | one curve sample request
//   out     | out_valid/out_ready, level, saturated   | one rounded, clipped level
//
// One transaction enters per cycle while in_ready is high. Its result is registered through
// 25 register stages: one input stage, 17 divider stages (one quotient bit each) and
// 7 polynomial stages. Sustained rate is one sample per clock while out_ready stays high.
// Reset (rst_n low, synchronous) empties every stage; no payload is cleared.
// A stall at out holds each full stage; empty stages still fill, so in_ready
// drops only when every stage holds a transaction.

`include "hermite_contrast_curve_point_defines.svh"

module hermite_contrast_curve_point
  import hccp_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  output logic   in_ready,
  input  lvl_t   in_left_x,
  input  lvl_t   in_left_y,
  input  slope_t in_left_slope,
  input  lvl_t   in_right_x,
  input  lvl_t   in_right_y,
  input  slope_t in_right_slope,
  input  lvl_t   in_position,
  output logic   out_valid,
  input  logic   out_ready,
  output lvl_t   out_level,
  output logic   out_saturated
);

  // ---------------------------------------------------------------------
  // Input stage: clamp the position, form the division numerator.
  // ---------------------------------------------------------------------
  logic                s0_vld_r;
  logic                s0_rdy;
  logic [NUM_BITS-1:0] s0_num_r;
  logic [NUM_BITS-1:0] s0_num_nxt;
  side_t               s0_side_r;
  side_t               s0_side_nxt;
  lvl_t                pos_lo;
  lvl_t                pos_c;
  lvl_t                pos_off;
  lvl_t                span;

  always_comb begin
    span    = in_right_x - in_left_x;
    pos_lo  = (in_position < in_left_x) ? in_left_x : in_position;
    pos_c   = (pos_lo > in_right_x) ? in_right_x : pos_lo;
    pos_off = pos_c - in_left_x;
    // Numerator d * 2^16 + floor(span / 2) gives round-half-up division.
    s0_num_nxt        = {pos_off, FRAC_BITS'(0)} + NUM_BITS'(span >> 1);
    s0_side_nxt.zspan = in_right_x <= in_left_x;
    s0_side_nxt.span  = span;
    s0_side_nxt.ly    = in_left_y;
    s0_side_nxt.ry    = in_right_y;
    s0_side_nxt.m1    = in_left_slope;
    s0_side_nxt.m2    = in_right_slope;
  end

  // ---------------------------------------------------------------------
  // Divider: t = round(d / span) in Q1.16.
  // ---------------------------------------------------------------------
  logic              div_in_ready;
  logic              div_vld;
  logic              sq_rdy;
  logic [T_BITS-1:0] div_quo;
  side_t             div_side;

  hccp_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s0_vld_r),
    .in_ready  (div_in_ready),
    .in_num    (s0_num_r),
    .in_side   (s0_side_r),
    .out_valid (div_vld),
    .out_ready (sq_rdy),
    .out_quo   (div_quo),
    .out_side  (div_side)
  );

  // ---------------------------------------------------------------------
  // Polynomial stages.
  // ---------------------------------------------------------------------
  logic sq_vld_r, cu_vld_r, bs_vld_r, pr_vld_r, ad_vld_r, sc_vld_r, out_vld_r;
  logic cu_rdy, bs_rdy, pr_rdy, ad_rdy, sc_rdy, out_rdy;

  // Square of t.
  logic [T_BITS-1:0]  sq_t_r;
  logic [SQ_BITS-1:0] sq_prod_r;
  side_t              sq_side_r;

  // Rounded t^2 and the raw cube product.
  logic [T_BITS-1:0]  cu_t_r;
  logic [T_BITS-1:0]  cu_t2_r;
  logic [T_BITS-1:0]  cu_t2_nxt;
  logic [SQ_BITS-1:0] cu_prod_r;
  logic [SQ_BITS-1:0] sq_round;
  side_t              cu_side_r;

  // Basis values.
  logic [SQ_BITS-1:0]        cu_round;
  logic [T_BITS-1:0]         t3;
  logic signed [H_BITS-1:0]  st;
  logic signed [H_BITS-1:0]  st2;
  logic signed [H_BITS-1:0]  st3;
  logic signed [H_BITS-1:0]  bs_h00_r, bs_h10_r, bs_h01_r, bs_h11_r;
  logic signed [H_BITS-1:0]  bs_h00_nxt, bs_h10_nxt, bs_h01_nxt, bs_h11_nxt;
  side_t                     bs_side_r;

  // Products with levels and slopes.
  logic signed [PY_BITS-1:0] pr_ly_r, pr_ry_r, pr_ly_nxt, pr_ry_nxt;
  logic signed [PM_BITS-1:0] pr_m1_r, pr_m2_r, pr_m1_nxt, pr_m2_nxt;
  side_t                     pr_side_r;

  // Partial sums.
  logic signed [PY_BITS:0]   ad_ya_r;
  logic signed [PM_BITS:0]   ad_mb_r;
  side_t                     ad_side_r;

  // Slope part scaled by the span.
  logic signed [PY_BITS:0]   sc_ya_r;
  logic signed [MS_BITS-1:0] sc_ms_r;
  logic signed [MS_BITS-1:0] sc_ms_nxt;
  side_t                     sc_side_r;

  // Final sum, rounding and clipping.
  logic signed [SUM_BITS-1:0] total;
  lvl_t                       out_level_r, out_level_nxt;
  logic                       out_sat_r, out_sat_nxt;

  // Ready chain: a stage moves when empty or when its successor moves.
  assign out_rdy = ~out_vld_r | out_ready;
  assign sc_rdy  = ~sc_vld_r | out_rdy;
  assign ad_rdy  = ~ad_vld_r | sc_rdy;
  assign pr_rdy  = ~pr_vld_r | ad_rdy;
  assign bs_rdy  = ~bs_vld_r | pr_rdy;
  assign cu_rdy  = ~cu_vld_r | bs_rdy;
  assign sq_rdy  = ~sq_vld_r | cu_rdy;
  assign s0_rdy  = ~s0_vld_r | div_in_ready;

  // Rounding of t^2, then the product t^2 * t.
  always_comb begin
    sq_round  = sq_prod_r + SQ_ROUND;
    cu_t2_nxt = sq_round[FRAC_BITS +: T_BITS];
  end

  // Rounding of t^3 and the four Hermite basis polynomials.
  always_comb begin
    cu_round   = cu_prod_r + SQ_ROUND;
    t3         = cu_round[FRAC_BITS +: T_BITS];
    st         = H_BITS'(cu_t_r);
    st2        = H_BITS'(cu_t2_r);
    st3        = H_BITS'(t3);
    bs_h00_nxt = (st3 <<< 1) - (st2 <<< 1) - st2 + T_ONE_H;
    bs_h10_nxt = st3 - (st2 <<< 1) + st;
    bs_h01_nxt = (st2 <<< 1) + st2 - (st3 <<< 1);
    bs_h11_nxt = st3 - st2;
  end

  // Basis times levels and slopes.
  always_comb begin
    pr_ly_nxt = PY_BITS'(bs_h00_r) * PY_BITS'($signed({1'b0, bs_side_r.ly}));
    pr_ry_nxt = PY_BITS'(bs_h01_r) * PY_BITS'($signed({1'b0, bs_side_r.ry}));
    pr_m1_nxt = PM_BITS'(bs_h10_r) * PM_BITS'(bs_side_r.m1);
    pr_m2_nxt = PM_BITS'(bs_h11_r) * PM_BITS'(bs_side_r.m2);
  end

  // Slope sum scaled by the span.
  assign sc_ms_nxt = MS_BITS'(ad_mb_r) * MS_BITS'($signed({1'b0, ad_side_r.span}));

  // Sum in Q.24, round half up, clip to the level range; a zero or reversed span passes the left level.
  always_comb begin
    total = (SUM_BITS'(sc_ya_r) <<< SLOPE_FRAC) + SUM_BITS'(sc_ms_r) + OUT_ROUND;
    if (sc_side_r.zspan) begin
      out_level_nxt = sc_side_r.ly;
      out_sat_nxt   = 1'b0;
    end else if (total[SUM_BITS-1]) begin
      out_level_nxt = '0;
      out_sat_nxt   = 1'b1;
    end else if (total[SUM_BITS-1:OUT_SHIFT] > (SUM_BITS - OUT_SHIFT)'(LVL_MAX)) begin
      out_level_nxt = LVL_MAX;
      out_sat_nxt   = 1'b1;
    end else begin
      out_level_nxt = total[OUT_SHIFT +: LEVEL_BITS];
      out_sat_nxt   = 1'b0;
    end
  end

  // Valid bits for the input and polynomial stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r  <= 1'b0;
      sq_vld_r  <= 1'b0;
      cu_vld_r  <= 1'b0;
      bs_vld_r  <= 1'b0;
      pr_vld_r  <= 1'b0;
      ad_vld_r  <= 1'b0;
      sc_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (s0_rdy)  s0_vld_r  <= in_valid;
      if (sq_rdy)  sq_vld_r  <= div_vld;
      if (cu_rdy)  cu_vld_r  <= sq_vld_r;
      if (bs_rdy)  bs_vld_r  <= cu_vld_r;
      if (pr_rdy)  pr_vld_r  <= bs_vld_r;
      if (ad_rdy)  ad_vld_r  <= pr_vld_r;
      if (sc_rdy)  sc_vld_r  <= ad_vld_r;
      if (out_rdy) out_vld_r <= sc_vld_r;
    end
  end

  // Stage payload registers.
  always_ff @(posedge clk) begin
    if (s0_rdy) begin
      s0_num_r  <= s0_num_nxt;
      s0_side_r <= s0_side_nxt;
    end
    if (sq_rdy) begin
      sq_t_r    <= div_quo;
      sq_prod_r <= SQ_BITS'(div_quo) * SQ_BITS'(div_quo);
      sq_side_r <= div_side;
    end
    if (cu_rdy) begin
      cu_t_r    <= sq_t_r;
      cu_t2_r   <= cu_t2_nxt;
      cu_prod_r <= SQ_BITS'(cu_t2_nxt) * SQ_BITS'(sq_t_r);
      cu_side_r <= sq_side_r;
    end
    if (bs_rdy) begin
      bs_h00_r  <= bs_h00_nxt;
      bs_h10_r  <= bs_h10_nxt;
      bs_h01_r  <= bs_h01_nxt;
      bs_h11_r  <= bs_h11_nxt;
      bs_side_r <= cu_side_r;
    end
    if (pr_rdy) begin
      pr_ly_r   <= pr_ly_nxt;
      pr_ry_r   <= pr_ry_nxt;
      pr_m1_r   <= pr_m1_nxt;
      pr_m2_r   <= pr_m2_nxt;
      pr_side_r <= bs_side_r;
    end
    if (ad_rdy) begin
      ad_ya_r   <= (PY_BITS + 1)'(pr_ly_r) + (PY_BITS + 1)'(pr_ry_r);
      ad_mb_r   <= (PM_BITS + 1)'(pr_m1_r) + (PM_BITS + 1)'(pr_m2_r);
      ad_side_r <= pr_side_r;
    end
    if (sc_rdy) begin
      sc_ya_r   <= ad_ya_r;
      sc_ms_r   <= sc_ms_nxt;
      sc_side_r <= ad_side_r;
    end
    if (out_rdy) begin
      out_level_r <= out_level_nxt;
      out_sat_r   <= out_sat_nxt;
    end
  end

  assign in_ready      = s0_rdy;
  assign out_valid     = out_vld_r;
  assign out_level     = out_level_r;
  assign out_saturated = out_sat_r;

  // ---------------------------------------------------------------------
  // Assertions. A zero or reversed span leaves the quotient meaningless.
  // ---------------------------------------------------------------------
  `HCCP_CHECK(a_quo_range, div_vld && !div_side.zspan, div_quo <= T_ONE, "quotient above one")
  `HCCP_CHECK(a_basis_sum, bs_vld_r, (bs_h00_r + bs_h01_r) == T_ONE_H, "h00 + h01 is not one")
  `HCCP_CHECK_NEXT(a_zspan_clean, sc_vld_r && out_rdy && sc_side_r.zspan, !out_saturated, "zero span clipped")
  `HCCP_CHECK(a_sat_level, out_vld_r && out_saturated, out_level == '0 || out_level == LVL_MAX, "clipped level inside range")
  `HCCP_CHECK_NEXT(a_stall_hold, sc_vld_r && !out_rdy, sc_vld_r, "stalled stage lost its transaction")

endmodule

[test/hermite_contrast_curve_point_tb.sv]
// Self-checking testbench for hermite_contrast_curve_point: drives curve sample
// transactions with random idling on both channels and checks each level.
// Depends on hccp_pkg and the RTL of the block.

module hermite_contrast_curve_point_tb
  import hccp_pkg::*;
();

  // One curve sample request, in port order.
  typedef struct packed {
    lvl_t   left_x;
    lvl_t   left_y;
    slope_t left_slope;
    lvl_t   right_x;
    lvl_t   right_y;
    slope_t right_slope;
    lvl_t   position;
  } curve_sample_t;

  // One expected or observed result transaction.
  typedef struct packed {
    lvl_t level;
    logic saturated;
  } curve_level_t;

  class level_scoreboard;
    curve_level_t pending_levels[$];
    int errors;
    int checked;
    int clipped;

    // Prints one line per mismatch and counts it.
    task report(string what);
      $display("MISMATCH at result %0d: %s", checked, what);
      errors++;
    endtask

    // Evaluates the Hermite curve in fixed point: t is Q1.16, the sum is Q.24.
    function curve_level_t hermite_level(curve_sample_t smp);
      longint lx, rx, ly, ry, m1, m2, pos;
      longint span, dist_x, t, t2, t3, h00, h10, h01, h11, sum, rnd, q;
      curve_level_t res;
      res.saturated = 1'b0;
      res.level = smp.left_y;
      lx = longint'(smp.left_x);
      rx = longint'(smp.right_x);
      ly = longint'(smp.left_y);
      ry = longint'(smp.right_y);
      m1 = longint'(smp.left_slope);
      m2 = longint'(smp.right_slope);
      pos = longint'(smp.position);
      // A zero or reversed span returns the left level unchanged.
      if (rx <= lx) begin
        return res;
      end
      span = rx - lx;
      // Positions outside the points are clamped to the nearer point.
      if (pos < lx) pos = lx;
      if (pos > rx) pos = rx;
      dist_x = pos - lx;
      t = (dist_x * 65536 + span / 2) / span;
      t2 = (t * t + 32768) >>> 16;
      t3 = (t2 * t + 32768) >>> 16;
      h00 = 2 * t3 - 3 * t2 + 65536;
      h10 = t3 - 2 * t2 + t;
      h01 = -2 * t3 + 3 * t2;
      h11 = t3 - t2;
      sum = (h00 * ly + h01 * ry) * 256 + (h10 * m1 + h11 * m2) * span;
      rnd = sum + (longint'(1) <<< 23);
      // Round half up, then clip to the level range.
      if (rnd < 0) begin
        res.level = '0;
        res.saturated = 1'b1;
      end else begin
        q = rnd >>> 24;
        if (q > longint'(LVL_MAX)) begin
          res.level = LVL_MAX;
          res.saturated = 1'b1;
        end else begin
          res.level = lvl_t'(q);
        end
      end
      return res;
    endfunction

    // Called for every accepted input transaction.
    function void note_sample(curve_sample_t smp);
      pending_levels.insert(pending_levels.size(), hermite_level(smp));
    endfunction

    // Called for every accepted output transaction.
    task check_result(lvl_t level, logic saturated);
      curve_level_t exp_lvl;
      if (pending_levels.size() == 0) begin
        report($sformatf("unexpected result level=%0d saturated=%0b", level, saturated));
      end else begin
        exp_lvl = pending_levels.pop_front();
        if (level !== exp_lvl.level)
          report($sformatf("level got %0d, expected %0d", level, exp_lvl.level));
        if (saturated !== exp_lvl.saturated)
          report($sformatf("saturated got %0b, expected %0b", saturated, exp_lvl.saturated));
        if (exp_lvl.saturated) clipped++;
      end
      checked++;
    endtask
  endclass

  logic   clk = 1'b0;
  logic   rst_n = 1'b0;
  logic   in_valid = 1'b0;
  logic   in_ready;
  lvl_t   in_left_x = '0;
  lvl_t   in_left_y = '0;
  slope_t in_left_slope = '0;
  lvl_t   in_right_x = '0;
  lvl_t   in_right_y = '0;
  slope_t in_right_slope = '0;
  lvl_t   in_position = '0;
  logic   out_valid;
  logic   out_ready = 1'b0;
  lvl_t   out_level;
  logic   out_saturated;

  level_scoreboard sb = new;
  int idle_pct = 35;
  int sent = 0;
  int zero_spans = 0;
  int outside = 0;

  hermite_contrast_curve_point dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_left_x      (in_left_x),
    .in_left_y      (in_left_y),
    .in_left_slope  (in_left_slope),
    .in_right_x     (in_right_x),
    .in_right_y     (in_right_y),
    .in_right_slope (in_right_slope),
    .in_position    (in_position),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_level      (out_level),
    .out_saturated  (out_saturated)
  );

  // Free-running clock, period 10.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: checks each accepted result transaction and stalls at random.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_level, out_saturated);
    out_ready <= ($urandom_range(99) >= idle_pct);
  end

  // Presents one transaction after a random gap and returns at the edge
  // where it was accepted.
  task automatic send_sample(curve_sample_t smp);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_left_x      <= smp.left_x;
    in_left_y      <= smp.left_y;
    in_left_slope  <= smp.left_slope;
    in_right_x     <= smp.right_x;
    in_right_y     <= smp.right_y;
    in_right_slope <= smp.right_slope;
    in_position    <= smp.position;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_sample(smp);
    sent++;
    if (smp.right_x <= smp.left_x) zero_spans++;
    else if (smp.position < smp.left_x || smp.position > smp.right_x) outside++;
  endtask

  // Holds off the sender until every expected level has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending_levels.size() != 0);
  endtask

  // Slope with either full range or a moderate magnitude.
  function automatic slope_t rand_slope();
    if ($urandom_range(1)) return slope_t'($urandom);
    return slope_t'(int'($urandom_range(1023)) - 512);
  endfunction

  // Stimulus: directed corner cases, then random curve samples.
  initial begin
    curve_sample_t smp;
    int kind;
    int lx;
    int rx;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Zero and reversed spans.
    send_sample('{8'd100, 8'd77, 12'sh7FF, 8'd100, 8'd200, 12'sh800, 8'd100});
    send_sample('{8'd100, 8'd255, 12'sh000, 8'd100, 8'd0, 12'sh000, 8'd3});
    send_sample('{8'd200, 8'd3, 12'sh123, 8'd50, 8'd250, 12'sh456, 8'd120});
    send_sample('{8'd255, 8'd0, 12'sh800, 8'd0, 8'd255, 12'sh7FF, 8'd255});
    send_sample('{8'd255, 8'd255, 12'shFFF, 8'd255, 8'd255, 12'shFFF, 8'd255});
    send_sample('{8'd0, 8'd0, 12'sh000, 8'd0, 8'd0, 12'sh000, 8'd0});
    // Full-range ramp at both ends and the middle.
    send_sample('{8'd0, 8'd0, 12'sh000, 8'd255, 8'd255, 12'sh000, 8'd0});
    send_sample('{8'd0, 8'd0, 12'sh000, 8'd255, 8'd255, 12'sh000, 8'd128});
    send_sample('{8'd0, 8'd0, 12'sh000, 8'd255, 8'd255, 12'sh000, 8'd255});
    // Position outside the points, below and above.
    send_sample('{8'd50, 8'd10, 12'sh000, 8'd150, 8'd240, 12'sh000, 8'd10});
    send_sample('{8'd50, 8'd10, 12'sh000, 8'd150, 8'd240, 12'sh000, 8'd250});
    // Extreme slopes that drive the curve past the top and the bottom.
    send_sample('{8'd0, 8'd128, 12'sh7FF, 8'd255, 8'd128, 12'sh800, 8'd64});
    send_sample('{8'd0, 8'd128, 12'sh800, 8'd255, 8'd128, 12'sh7FF, 8'd128});
    send_sample('{8'd10, 8'd255, 12'sh7FF, 8'd250, 8'd0, 12'sh7FF, 8'd240});
    send_sample('{8'd0, 8'd255, 12'sh000, 8'd200, 8'd255, 12'sh000, 8'd100});
    // Span of one and a half-way rounding case.
    send_sample('{8'd254, 8'd0, 12'sh7FF, 8'd255, 8'd255, 12'sh800, 8'd254});
    send_sample('{8'd254, 8'd0, 12'sh7FF, 8'd255, 8'd255, 12'sh800, 8'd255});
    send_sample('{8'd0, 8'd0, 12'sh000, 8'd2, 8'd1, 12'sh000, 8'd1});
    send_sample('{8'd3, 8'd200, 12'sh555, 8'd251, 8'd17, 12'shAAA, 8'd131});

    for (int n = 0; n < 1550; n++) begin
      // A calm stretch with no idling on either channel.
      idle_pct = (n >= 600 && n < 900) ? 0 : 35;
      if (n == 400 || n == 1100) drain_results();
      kind = $urandom_range(99);
      smp.left_y = lvl_t'($urandom);
      smp.right_y = lvl_t'($urandom);
      smp.left_slope = rand_slope();
      smp.right_slope = rand_slope();
      if (kind < 76) begin
        // Well-formed points with the position between them.
        lx = $urandom_range(255);
        rx = $urandom_range(255, lx);
        smp.position = lvl_t'($urandom_range(rx, lx));
      end else if (kind < 88) begin
        // Narrow spans.
        lx = $urandom_range(250);
        rx = lx + $urandom_range(5);
        smp.position = lvl_t'($urandom_range(rx, lx));
      end else if (kind < 94) begin
        // Position outside the points.
        lx = $urandom_range(200, 16);
        rx = $urandom_range(239, lx + 1);
        smp.position = $urandom_range(1) ? lvl_t'($urandom_range(lx - 1))
                                         : lvl_t'($urandom_range(255, rx + 1));
      end else begin
        // Unconstrained noise, reversed spans included.
        lx = $urandom_range(255);
        rx = $urandom_range(255);
        smp.position = lvl_t'($urandom);
      end
      smp.left_x = lvl_t'(lx);
      smp.right_x = lvl_t'(rx);
      send_sample(smp);
    end

    in_valid <= 1'b0;
    while (sb.pending_levels.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Sent %0d curve samples: %0d with zero or reversed span, %0d clamped.",
             sent, zero_spans, outside);
    $display("Checked %0d levels, %0d clipped, %0d mismatches.",
             sb.checked, sb.clipped, sb.errors);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #2000000;
    $display("Timeout: %0d levels still outstanding", sb.pending_levels.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
